FILE: hw/rtl/fcull_pkg.sv
package fcull_pkg;

  // Plane store
  localparam int PLANE_COUNT = 6;   // cells in the chain, 1..8
  localparam int REG_COUNT   = 6;   // writable plane registers
  localparam int CFG_IDX_W   = 3;
  localparam int PLANE_W     = 64;
  localparam int NORM_W      = 16;  // nx, ny, nz in Q1.14, d in coordinate units
  localparam int NORM_FRAC   = 14;

  // Object coordinates
  localparam int COORD_BITS  = 16;  // 8..32
  localparam int RAD_W       = 16;

  // Products and plane distance
  localparam int PROD_W      = COORD_BITS + NORM_W;
  localparam int DTERM_W     = NORM_W + NORM_FRAC;
  localparam int DIST_W      = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_POINT  = 2'd0;
  localparam cmd_t CMD_BOX    = 2'd1;
  localparam cmd_t CMD_SPHERE = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    cmd_t             cmd;
    coord_t           ax;
    coord_t           ay;
    coord_t           az;
    coord_t           bx;
    coord_t           by;
    coord_t           bz;
    logic [RAD_W-1:0] sphere_radius;
  } obj_t;

  // What one cell hands to the next
  typedef struct packed {
    obj_t obj;
    logic visible;
  } cell_beat_t;

endpackage

FILE: hw/rtl/fcull_if.sv
interface fcull_in_if;
  logic                                valid;
  logic                                ready;
  fcull_pkg::cmd_t                     cmd;
  fcull_pkg::coord_t                   ax;
  fcull_pkg::coord_t                   ay;
  fcull_pkg::coord_t                   az;
  fcull_pkg::coord_t                   bx;
  fcull_pkg::coord_t                   by;
  fcull_pkg::coord_t                   bz;
  logic [fcull_pkg::RAD_W-1:0]         sphere_radius;

  modport source (output valid, output cmd, output ax, output ay, output az,
                  output bx, output by, output bz, output sphere_radius,
                  input ready);
  modport sink   (input valid, input cmd, input ax, input ay, input az,
                  input bx, input by, input bz, input sphere_radius,
                  output ready);
endinterface

interface fcull_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

FILE: hw/rtl/fcull_cell.sv
// One plane of the chain: stage A picks the corner and multiplies,
// stage B sums, compares and folds the verdict into the beat.
module fcull_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             plane_we_i,
  input  logic [fcull_pkg::PLANE_W-1:0]    plane_i,
  input  logic                             up_valid_i,
  output logic                             up_ready_o,
  input  fcull_pkg::cell_beat_t            up_beat_i,
  output logic                             dn_valid_o,
  input  logic                             dn_ready_i,
  output fcull_pkg::cell_beat_t            dn_beat_o
);

  localparam int PROD_W = fcull_pkg::PROD_W;
  localparam int DIST_W = fcull_pkg::DIST_W;
  localparam int NORM_W = fcull_pkg::NORM_W;

  logic [fcull_pkg::PLANE_W-1:0] plane_q;

  logic signed [NORM_W-1:0] nx, ny, nz, nd;
  assign nx = plane_q[NORM_W-1:0];
  assign ny = plane_q[2*NORM_W-1:NORM_W];
  assign nz = plane_q[3*NORM_W-1:2*NORM_W];
  assign nd = plane_q[4*NORM_W-1:3*NORM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (plane_we_i) begin
      plane_q <= plane_i;
    end
  end

  // stage A
  logic                  a_valid_q;
  fcull_pkg::cell_beat_t a_beat_q;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [PROD_W-1:0] px_d, py_d, pz_d;
  fcull_pkg::coord_t     x, y, z;
  logic                  a_ready, b_ready;

  // stage B
  logic                  b_valid_q;
  fcull_pkg::cell_beat_t b_beat_q;

  assign b_ready    = !b_valid_q || dn_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign up_ready_o = a_ready;

  // box: corner farthest along the normal on each axis
  always_comb begin
    x = up_beat_i.obj.ax;
    y = up_beat_i.obj.ay;
    z = up_beat_i.obj.az;
    if (up_beat_i.obj.cmd == fcull_pkg::CMD_BOX) begin
      if (nx >= 0) x = (up_beat_i.obj.ax > up_beat_i.obj.bx) ? up_beat_i.obj.ax
                                                             : up_beat_i.obj.bx;
      else         x = (up_beat_i.obj.ax > up_beat_i.obj.bx) ? up_beat_i.obj.bx
                                                             : up_beat_i.obj.ax;
      if (ny >= 0) y = (up_beat_i.obj.ay > up_beat_i.obj.by) ? up_beat_i.obj.ay
                                                             : up_beat_i.obj.by;
      else         y = (up_beat_i.obj.ay > up_beat_i.obj.by) ? up_beat_i.obj.by
                                                             : up_beat_i.obj.ay;
      if (nz >= 0) z = (up_beat_i.obj.az > up_beat_i.obj.bz) ? up_beat_i.obj.az
                                                             : up_beat_i.obj.bz;
      else         z = (up_beat_i.obj.az > up_beat_i.obj.bz) ? up_beat_i.obj.bz
                                                             : up_beat_i.obj.az;
    end
  end

  assign px_d = PROD_W'(nx) * PROD_W'(x);
  assign py_d = PROD_W'(ny) * PROD_W'(y);
  assign pz_d = PROD_W'(nz) * PROD_W'(z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && up_valid_i) begin
      a_beat_q <= up_beat_i;
      px_q     <= px_d;
      py_q     <= py_d;
      pz_q     <= pz_d;
    end
  end

  logic signed [DIST_W-1:0] dist_sum, limit, d_term;
  logic                     reject;

  assign d_term   = DIST_W'(nd) <<< fcull_pkg::NORM_FRAC;
  assign dist_sum = DIST_W'(px_q) + DIST_W'(py_q) + DIST_W'(pz_q) + d_term;
  assign limit    = (a_beat_q.obj.cmd == fcull_pkg::CMD_SPHERE)
                  ? -($signed(DIST_W'(a_beat_q.obj.sphere_radius)) <<< fcull_pkg::NORM_FRAC)
                  : '0;
  assign reject   = dist_sum < limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_beat_q.obj     <= a_beat_q.obj;
      b_beat_q.visible <= a_beat_q.visible && !reject;
    end
  end

  assign dn_valid_o = b_valid_q;
  assign dn_beat_o  = b_beat_q;

endmodule

FILE: hw/rtl/frustum_cull_test_top.sv
// Channel   Dir  Payload                                      Beat when
// in_i      in   cmd, ax..az, bx..bz, sphere_radius           in_i.valid && in_i.ready
// out_o     out  inside_res                                   out_o.valid && out_o.ready
// cfg       in   cfg_idx_i (plane 0..5), cfg_data_i (64 bit)  cfg_we_i
//
// One object accepted per cycle while the chain is not stalled; each result passes
// through the chain of plane cells, two register stages each (multiply, then
// sum and compare). Output beat comes straight from the last cell's stage.
// Async active-low reset clears all planes to zero and empties the chain.
// Each stage holds only when it is full and its successor is stalled, so
// bubbles in the chain still absorb new objects while a result waits.
module frustum_cull_test_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fcull_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fcull_pkg::PLANE_W-1:0]      cfg_data_i,
  fcull_in_if.sink                           in_i,
  fcull_out_if.source                        out_o
);

  localparam int N = fcull_pkg::PLANE_COUNT;

  // chain links: link 0 feeds cell 0, link N leaves the last cell
  logic                  link_valid [N+1];
  logic                  link_ready [N+1];
  fcull_pkg::cell_beat_t link_beat  [N+1];

  // head of the chain: nothing rejected yet
  assign link_valid[0]                  = in_i.valid;
  assign in_i.ready                     = link_ready[0];
  assign link_beat[0].obj.cmd           = in_i.cmd;
  assign link_beat[0].obj.ax            = in_i.ax;
  assign link_beat[0].obj.ay            = in_i.ay;
  assign link_beat[0].obj.az            = in_i.az;
  assign link_beat[0].obj.bx            = in_i.bx;
  assign link_beat[0].obj.by            = in_i.by;
  assign link_beat[0].obj.bz            = in_i.bz;
  assign link_beat[0].obj.sphere_radius = in_i.sphere_radius;
  assign link_beat[0].visible           = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic plane_we;

    // planes past the register list stay zero and never reject
    if (i < fcull_pkg::REG_COUNT) begin : g_we
      assign plane_we = cfg_we_i && (cfg_idx_i == fcull_pkg::CFG_IDX_W'(i));
    end else begin : g_no_we
      assign plane_we = 1'b0;
    end

    fcull_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .plane_we_i (plane_we),
      .plane_i    (cfg_data_i),
      .up_valid_i (link_valid[i]),
      .up_ready_o (link_ready[i]),
      .up_beat_i  (link_beat[i]),
      .dn_valid_o (link_valid[i+1]),
      .dn_ready_i (link_ready[i+1]),
      .dn_beat_o  (link_beat[i+1])
    );
  end

  assign out_o.valid      = link_valid[N];
  assign link_ready[N]    = out_o.ready;
  assign out_o.inside_res = link_beat[N].visible;

endmodule
